// ===== rtl/core/srpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stepper ramp period generator.
// No dependencies; imported by every module of the block except srpg_ram.
package srpg_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 1024;

   localparam int unsigned PERIOD_W  = 32;
   localparam int unsigned TIME_W    = 48;
   localparam int unsigned CFG_W     = 48;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned DIV_W     = 48;
   localparam int unsigned PROD_W    = 64;
   localparam int unsigned SUM_W     = 65;
   localparam int unsigned DEN_W     = 81;

   // operation codes of the request channel
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_RATE_SQ = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_RATE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_TERM    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD    = 3'd4;

   localparam logic [CFG_W-1:0]    RST_CLOCK_RATE_SQ = 48'd1000000000000;
   localparam logic [CFG_W-1:0]    RST_BASE_RATE     = 48'd100000000;
   localparam logic [PERIOD_W-1:0] RST_ACCEL_TERM    = 32'd800;
   localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD    = 32'd10000;
   localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD    = 32'd500;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_status_type;

endpackage

// ===== rtl/core/srpg_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srpg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srpg_div.sv =====
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// Depends on srpg_pkg for widths and the status struct.
module srpg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srpg_pkg::DIV_W-1:0]    numer,
   input  logic [srpg_pkg::DIV_W-1:0]    denom,
   output srpg_pkg::div_status_type      status
);
   import srpg_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   trial_sub;
   logic             fits;

   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign fits      = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

// ===== rtl/core/stepper_ramp_period_generator.sv =====
`timescale 1ns / 1ps
// A start or a finished move goes straight to ST_OUT; a deceleration or cruise step
// passes DECIDE, SCALE and POST; the low-speed span adds PUSH; the curve adds MUL_LO,
// MUL_HI, DEN, CHECK, PUSH and usually DIV. One transaction in flight at a time; the
// next request is taken the cycle after the result enters the output register.
// Reset (synchronous) clears the control state, count, elapsed time and stack level and
// restores the configuration defaults; the period stack RAM is not cleared.
module stepper_ramp_period_generator #(
   parameter int unsigned STACK_DEPTH = srpg_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [srpg_pkg::PERIOD_W-1:0]       req_step_count,
   input  logic                                req_scale_enable,
   input  logic [srpg_pkg::PERIOD_W-1:0]       req_ratio,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [srpg_pkg::PERIOD_W-1:0]       rsp_period,
   output logic                                rsp_done_res,
   // configuration write port
   input  logic                                csr_we,
   input  logic [srpg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srpg_pkg::CFG_W-1:0]          csr_wdata
);
   import srpg_pkg::*;

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_DECIDE = 11'b00000000010,
      ST_MUL_LO = 11'b00000000100,
      ST_MUL_HI = 11'b00000001000,
      ST_DEN    = 11'b00000010000,
      ST_CHECK  = 11'b00000100000,
      ST_DIV    = 11'b00001000000,
      ST_PUSH   = 11'b00010000000,
      ST_SCALE  = 11'b00100000000,
      ST_POST   = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [CFG_W-1:0]    crsq_ff, crsq_in;
   logic [CFG_W-1:0]    base_ff, base_in;
   logic [PERIOD_W-1:0] accel_ff, accel_in;
   logic [PERIOD_W-1:0] max_ff, max_in;
   logic [PERIOD_W-1:0] min_ff, min_in;

   // axis state and per-transaction working registers
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [LW-1:0]       level_ff, level_in;
   logic                scale_ff, scale_in;
   logic [PERIOD_W-1:0] ratio_ff, ratio_in;
   logic [PERIOD_W-1:0] per_ff, per_in;
   logic [TIME_W-1:0]   diff_ff, diff_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [PERIOD_W-1:0] res_period_ff, res_period_in;
   logic                res_done_ff, res_done_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0] rsp_period_ff, rsp_period_in;
   logic                rsp_done_ff, rsp_done_in;

   // stack RAM and divider hookup
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [PERIOD_W-1:0] ram_rd_data;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [PERIOD_W-1:0] ram_wr_data;
   logic                div_start;
   div_status_type      div_stat;

   // datapath helpers
   logic [PERIOD_W-1:0] rem_dec;
   logic [LW-1:0]       level_m1;
   logic [PERIOD_W:0]   span;
   logic [PERIOD_W-1:0] mul_a;
   logic [PERIOD_W-1:0] mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [PERIOD_W-1:0] scaled;
   logic [PERIOD_W-1:0] fin_period;
   logic [TIME_W:0]     time_sum;
   logic [TIME_W-1:0]   time_sat;
   logic [PERIOD_W-1:0] clamped;
   logic                accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Count down, but hold at zero: a step with nothing left reports done.
   assign rem_dec  = rem_ff - PERIOD_W'(rem_ff != '0);
   assign level_m1 = level_ff - LW'(1);
   // The low-speed span lasts twice the slowest period.
   assign span     = {max_ff, 1'b0};

   // One shared 32x32 multiplier: the two halves of the curve slope, then the ratio.
   always_comb begin
      mul_a = accel_ff;
      mul_b = ratio_ff;
      case (state_ff)
         ST_MUL_LO: mul_b = diff_ff[PERIOD_W-1:0];
         ST_MUL_HI: mul_b = PERIOD_W'(diff_ff[TIME_W-1:PERIOD_W]);
         ST_SCALE:  mul_a = per_ff;
         default:   mul_b = ratio_ff;
      endcase
   end
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // UQ16.16 scaling: drop the fraction, saturate what no longer fits.
   assign scaled     = (prod_ff[PROD_W-1:TIME_W] != '0) ? '1 : prod_ff[TIME_W-1:16];
   assign fin_period = scale_ff ? scaled : per_ff;
   assign time_sum   = {1'b0, time_ff} + (TIME_W + 1)'(fin_period);
   assign time_sat   = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
   assign clamped    = (per_ff < min_ff) ? min_ff : per_ff;

   // The top of the stack always sits one below the level.
   assign ram_rd_addr = level_m1[AW-1:0];
   assign ram_wr_addr = level_ff[AW-1:0];
   assign ram_wr_data = clamped;

   always_comb begin
      state_in      = state_ff;
      crsq_in       = crsq_ff;
      base_in       = base_ff;
      accel_in      = accel_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      rem_in        = rem_ff;
      time_in       = time_ff;
      level_in      = level_ff;
      scale_in      = scale_ff;
      ratio_in      = ratio_ff;
      per_in        = per_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      den_in        = den_ff;
      res_period_in = res_period_ff;
      res_done_in   = res_done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_period_in = rsp_period_ff;
      rsp_done_in   = rsp_done_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      div_start     = 1'b0;

      // The user must change the configuration only while idle; the block does not enforce it.
      if (csr_we) begin
         case (csr_index)
            CSR_CLOCK_RATE_SQ: crsq_in  = csr_wdata;
            CSR_BASE_RATE:     base_in  = csr_wdata;
            CSR_ACCEL_TERM:    accel_in = csr_wdata[PERIOD_W-1:0];
            CSR_MAX_PERIOD:    max_in   = csr_wdata[PERIOD_W-1:0];
            CSR_MIN_PERIOD:    min_in   = csr_wdata[PERIOD_W-1:0];
            default:           crsq_in  = crsq_ff;
         endcase
      end

      // Drop the held response once the consumer takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scale_in = req_scale_enable;
               ratio_in = req_ratio;
               if (req_operation == OP_START) begin
                  // New move: load the count, clear time and stack, fire at once.
                  rem_in        = req_step_count;
                  time_in       = '0;
                  level_in      = '0;
                  res_period_in = '0;
                  res_done_in   = 1'b0;
                  state_in      = ST_OUT;
               end else begin
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     // Move finished: stop the timer, clear time and stack.
                     time_in       = '0;
                     level_in      = '0;
                     res_period_in = '0;
                     res_done_in   = 1'b1;
                     state_in      = ST_OUT;
                  end else begin
                     // Fetch the stack top; it is needed by both ramp decisions.
                     ram_rd_en = 1'b1;
                     state_in  = ST_DECIDE;
                  end
               end
            end
         end
         ST_DECIDE: begin
            if (PERIOD_W'(level_ff) >= rem_ff) begin
               // Decelerate: replay the saved ramp in reverse.
               level_in = level_m1;
               per_in   = ram_rd_data;
               state_in = ST_SCALE;
            end else if (level_ff == '0 || ram_rd_data > min_ff) begin
               // Accelerate along the curve.
               if (time_ff < TIME_W'(span)) begin
                  per_in   = max_ff;
                  state_in = ST_PUSH;
               end else begin
                  diff_in  = time_ff - TIME_W'(span);
                  state_in = ST_MUL_LO;
               end
            end else begin
               // Cruise at top speed.
               per_in   = min_ff;
               state_in = ST_SCALE;
            end
         end
         ST_MUL_LO: begin
            prod_in  = mul_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in  = mul_p;
            sum_in   = SUM_W'(base_ff) + SUM_W'(prod_ff);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in   = DEN_W'(sum_ff) + DEN_W'({prod_ff[TIME_W-1:0], 32'b0});
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               per_in   = '1;
               state_in = ST_PUSH;
            end else if (den_ff[DEN_W-1:DIV_W] != '0) begin
               // Denominator above the numerator range: quotient is zero.
               per_in   = '0;
               state_in = ST_PUSH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               per_in   = (div_stat.quotient[DIV_W-1:PERIOD_W] != '0) ? '1
                        : div_stat.quotient[PERIOD_W-1:0];
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // Clamp to the fastest period and save it unless the stack is full.
            per_in = clamped;
            if (level_ff < LW'(STACK_DEPTH)) begin
               ram_wr_en = 1'b1;
               level_in  = level_ff + LW'(1);
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = mul_p;
            state_in = ST_POST;
         end
         ST_POST: begin
            time_in       = time_sat;
            res_period_in = fin_period;
            res_done_in   = 1'b0;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            // Hold here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_period_in = res_period_ff;
               rsp_done_in   = res_done_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         crsq_ff      <= RST_CLOCK_RATE_SQ;
         base_ff      <= RST_BASE_RATE;
         accel_ff     <= RST_ACCEL_TERM;
         max_ff       <= RST_MAX_PERIOD;
         min_ff       <= RST_MIN_PERIOD;
         rem_ff       <= '0;
         time_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crsq_ff      <= crsq_in;
         base_ff      <= base_in;
         accel_ff     <= accel_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         rem_ff       <= rem_in;
         time_ff      <= time_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scale_ff      <= scale_in;
      ratio_ff      <= ratio_in;
      per_ff        <= per_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      den_ff        <= den_in;
      res_period_ff <= res_period_in;
      res_done_ff   <= res_done_in;
      rsp_period_ff <= rsp_period_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_period   = rsp_period_ff;
   assign rsp_done_res = rsp_done_ff;

   srpg_ram #(
      .WIDTH (PERIOD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   srpg_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (crsq_ff),
      .denom  (den_ff[DIV_W-1:0]),
      .status (div_stat)
   );

endmodule

// ===== rtl/core/srpg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the stepper ramp period generator, bound to the top level.
// Depends on srpg_pkg for port widths.
module srpg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [srpg_pkg::PERIOD_W-1:0]       rsp_period,
   input logic                                rsp_done_res
);
   import srpg_pkg::*;

   // Reset empties the output register.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A finished move carries no period.
   a_done_zero_period: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_period == '0))
      else $error("done response with nonzero period");

   // One transaction at a time: no request is taken right after another.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_period) && $stable(rsp_done_res)))
      else $error("stalled response changed");

endmodule

bind stepper_ramp_period_generator srpg_checker u_srpg_checker (.*);

// ===== tb/srpg_period_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the stepper ramp period generator: mirrors the axis state and
// the register file, predicts each response and compares it field by field.
// Depends on srpg_pkg.
module srpg_period_checker
   import srpg_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_operation,
   input  logic [PERIOD_W-1:0]  req_step_count,
   input  logic                 req_scale_enable,
   input  logic [PERIOD_W-1:0]  req_ratio,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [PERIOD_W-1:0]  rsp_period,
   input  logic                 rsp_done_res,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int unsigned          outstanding,
   output int unsigned          mismatches,
   output int unsigned          checked
);

   localparam bit [63:0] ALL_ONES = '1;
   localparam bit [63:0] SAT32    = 64'hFFFF_FFFF;
   localparam bit [63:0] SAT48    = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                done;
   } step_period_type;

   step_period_type expected_periods[$];

   // register copy, zero extended for 64-bit arithmetic
   bit [63:0] rate_sq;
   bit [63:0] base_rate;
   bit [63:0] accel;
   bit [63:0] max_per;
   bit [63:0] min_per;

   // axis state
   bit [31:0]   steps_left;
   bit [63:0]   elapsed;
   bit [31:0]   saved_periods[STACK_DEPTH];
   int unsigned depth_used;

   // speed curve: flat at max_per over the low-speed span, then rate_sq / denominator
   function automatic bit [63:0] ramp_curve(bit [63:0] t);
      bit [63:0] span;
      bit [63:0] diff;
      bit [63:0] den;
      bit [63:0] quot;
      span = max_per << 1;
      if (t < span) return max_per;
      diff = t - span;
      if (accel != 0 && diff > (ALL_ONES - base_rate) / accel) den = ALL_ONES;
      else den = base_rate + accel * diff;
      if (den == 0) return SAT32;
      quot = rate_sq / den;
      return (quot > SAT32) ? SAT32 : quot;
   endfunction

   function automatic step_period_type advance_axis(logic op, logic [31:0] count,
                                                    logic scale, logic [31:0] ratio);
      step_period_type res;
      bit [63:0]       per;
      res = '0;
      if (op == OP_START) begin
         steps_left = count;
         elapsed    = 0;
         depth_used = 0;
         return res;
      end
      if (steps_left != 0) steps_left--;
      if (steps_left == 0) begin
         elapsed    = 0;
         depth_used = 0;
         res.done   = 1'b1;
         return res;
      end
      if (depth_used >= steps_left) begin
         depth_used--;
         per = 64'(saved_periods[depth_used]);
      end else if (depth_used == 0 || 64'(saved_periods[depth_used-1]) > min_per) begin
         per = ramp_curve(elapsed);
         if (per < min_per) per = min_per;
         if (depth_used < STACK_DEPTH) begin
            saved_periods[depth_used] = per[31:0];
            depth_used++;
         end
      end else begin
         per = min_per;
      end
      if (scale) begin
         per = (per * 64'(ratio)) >> 16;
         if (per > SAT32) per = SAT32;
      end
      elapsed = elapsed + per;
      if (elapsed > SAT48) elapsed = SAT48;
      res.period = per[31:0];
      return res;
   endfunction

   function automatic void flag(string what, bit [63:0] want, bit [63:0] got);
      if (mismatches < 10)
         $display("srpg_chk: %s mismatch at %0t: expected %0h, got %0h",
                  what, $realtime, want, got);
      mismatches++;
   endfunction

   always @(posedge clock) begin : scoreboard
      step_period_type want;
      if (reset) begin
         rate_sq    = 64'(RST_CLOCK_RATE_SQ);
         base_rate  = 64'(RST_BASE_RATE);
         accel      = 64'(RST_ACCEL_TERM);
         max_per    = 64'(RST_MAX_PERIOD);
         min_per    = 64'(RST_MIN_PERIOD);
         steps_left = 0;
         elapsed    = 0;
         depth_used = 0;
         expected_periods.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CLOCK_RATE_SQ: rate_sq   = 64'(csr_wdata);
               CSR_BASE_RATE:     base_rate = 64'(csr_wdata);
               CSR_ACCEL_TERM:    accel     = 64'(csr_wdata[PERIOD_W-1:0]);
               CSR_MAX_PERIOD:    max_per   = 64'(csr_wdata[PERIOD_W-1:0]);
               CSR_MIN_PERIOD:    min_per   = 64'(csr_wdata[PERIOD_W-1:0]);
               default: ;
            endcase
         end
         // a response can never belong to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            checked <= checked + 1;
            if (expected_periods.size() == 0) begin
               flag("unexpected response, period", 0, 64'(rsp_period));
            end else begin
               want = expected_periods.pop_front();
               if (rsp_period !== want.period)
                  flag("period", 64'(want.period), 64'(rsp_period));
               if (rsp_done_res !== want.done)
                  flag("done_res", 64'(want.done), 64'(rsp_done_res));
            end
         end
         if (req_valid && req_ready)
            expected_periods.push_back(advance_axis(req_operation, req_step_count,
                                                    req_scale_enable, req_ratio));
         outstanding <= expected_periods.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the stepper ramp period generator testbench: clock, reset, stimulus
// and verdict. Depends on srpg_pkg, the generator RTL and srpg_period_checker.
module tb_top;
   import srpg_pkg::*;

   // a shallow stack lets a short move fill it
   localparam int unsigned TB_STACK_DEPTH = 16;
   localparam int unsigned RANDOM_ITEMS  = 675;
   localparam int unsigned RANDOM_PHASES = 9;
   localparam int unsigned DEEP_STEPS    = TB_STACK_DEPTH + 6;
   localparam int unsigned DEEP_COUNT    = 2 * TB_STACK_DEPTH + 52;
   localparam int unsigned DRAIN_CYCLES  = 64;
   localparam int unsigned CYCLE_LIMIT   = 2_000_000;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_operation    = OP_START;
   logic [PERIOD_W-1:0]  req_step_count   = '0;
   logic                 req_scale_enable = 1'b0;
   logic [PERIOD_W-1:0]  req_ratio        = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [PERIOD_W-1:0]  rsp_period;
   logic                 rsp_done_res;
   logic                 csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_CLOCK_RATE_SQ;
   logic [CFG_W-1:0]     csr_wdata        = '0;

   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned checked;

   // idle percentages for the two sides, changed per phase
   int unsigned tx_idle_pct = 38;
   int unsigned rx_idle_pct = 63;

   int unsigned sent_items  = 0;
   int unsigned sent_starts = 0;
   int unsigned cfg_sets    = 0;
   int unsigned cycle_count = 0;

   stepper_ramp_period_generator #(
      .STACK_DEPTH (TB_STACK_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_step_count   (req_step_count),
      .req_scale_enable (req_scale_enable),
      .req_ratio        (req_ratio),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_period       (rsp_period),
      .rsp_done_res     (rsp_done_res),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   srpg_period_checker #(
      .STACK_DEPTH (TB_STACK_DEPTH)
   ) period_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_step_count   (req_step_count),
      .req_scale_enable (req_scale_enable),
      .req_ratio        (req_ratio),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_period       (rsp_period),
      .rsp_done_res     (rsp_done_res),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .outstanding      (outstanding),
      .mismatches       (mismatches),
      .checked          (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stall the response side at random; at 0 percent ready stays high.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog: give up once the cycle budget is spent.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[stepper_ramp_period_generator] ERROR");
      $finish;
   end

   // Offer one request transaction and hold it until it is taken. Valid is
   // only dropped during a sender gap, so back-to-back requests never see a
   // low and a high assignment in the same step.
   task automatic send_req(logic op, logic [31:0] count, logic scale, logic [31:0] ratio);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_step_count   <= count;
      req_scale_enable <= scale;
      req_ratio        <= ratio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      if (op == OP_START) sent_starts++;
   endtask

   // Drop valid and wait until every predicted response has been seen. The
   // first edge lets the checker count the request taken just before.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Rewrite the whole register file while the block is idle.
   task automatic program_ramp(logic [47:0] rate_sq, logic [47:0] base, logic [31:0] accel,
                               logic [31:0] max_per, logic [31:0] min_per);
      drain();
      put_reg(CSR_CLOCK_RATE_SQ, rate_sq);
      put_reg(CSR_BASE_RATE, base);
      put_reg(CSR_ACCEL_TERM, 48'(accel));
      put_reg(CSR_MAX_PERIOD, 48'(max_per));
      put_reg(CSR_MIN_PERIOD, 48'(min_per));
      csr_we <= 1'b0;
      cfg_sets++;
   endtask

   // Mostly ramps short enough to reach cruise within a few dozen steps;
   // now and then a fully random register set.
   task automatic random_ramp();
      logic [47:0] rate_sq;
      logic [47:0] base;
      logic [31:0] accel;
      logic [31:0] max_per;
      logic [31:0] min_per;
      if ($urandom_range(9) == 0) begin
         rate_sq = 48'({$urandom, $urandom});
         base    = 48'({$urandom, $urandom});
         accel   = $urandom;
         max_per = $urandom;
         min_per = $urandom;
         if (rate_sq == 0) rate_sq = 1;
         if (base == 0) base = 1;
         if (max_per == 0) max_per = 1;
         if (min_per == 0) min_per = 1;
      end else begin
         max_per = $urandom_range(8, 400);
         min_per = $urandom_range(1, max_per / 3 + 1);
         base    = $urandom_range(100, 20000);
         rate_sq = base * max_per + $urandom_range(0, 999);
         accel   = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3000);
      end
      program_ramp(rate_sq, base, accel, max_per, min_per);
   endtask

   // Unity most often, then mild, fully random and edge ratios.
   function automatic logic [31:0] pick_ratio();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 30) return 32'h0001_0000;
      if (r < 55) return $urandom_range(32'h0000_2000, 32'h0004_0000);
      if (r < 80) return $urandom;
      case ($urandom_range(2))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [31:0] pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return 0;
      if (r < 65) return $urandom_range(1, 24);
      if (r < 92) return $urandom_range(25, 150);
      return $urandom;
   endfunction

   // One move: noise, an exact move, a move stepped past done, or a move cut
   // short by the next start. Huge counts are only stepped a little way.
   task automatic random_move();
      int unsigned kind;
      int unsigned steps;
      logic [31:0] count;
      logic        scale;
      logic [31:0] ratio;
      kind  = $urandom_range(99);
      scale = ($urandom_range(99) < 30);
      ratio = pick_ratio();
      if (kind < 8) begin
         send_req(logic'($urandom_range(1)), $urandom, logic'($urandom_range(1)), $urandom);
      end else begin
         count = pick_count();
         if (count > 150) steps = $urandom_range(1, 30);
         else steps = count + ((kind < 20) ? $urandom_range(1, 3) : 0);
         if (kind >= 85 && steps > 0) steps = $urandom_range(0, steps - 1);
         send_req(OP_START, count, scale, ratio);
         repeat (steps) begin
            // occasionally switch the axis role or ratio mid-move
            if ($urandom_range(99) < 10) begin
               scale = $urandom_range(1);
               ratio = pick_ratio();
            end
            send_req(OP_STEP, $urandom, scale, ratio);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned phase_goal;
      bit          paused;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, register defaults.
      send_req(OP_STEP, 32'd0, 1'b0, 32'h0001_0000);           // step with no move loaded
      send_req(OP_START, 32'd0, 1'b0, 32'h0001_0000);          // empty move
      send_req(OP_STEP, 32'd0, 1'b0, 32'h0001_0000);
      send_req(OP_START, 32'd4, 1'b0, 32'h0001_0000);          // span, span, pop, done
      repeat (4) send_req(OP_STEP, 32'hFFFF_FFFF, 1'b0, 32'h0001_0000);
      send_req(OP_START, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);  // zero ratio keeps time still
      send_req(OP_STEP, 32'd0, 1'b1, 32'h0000_0000);
      send_req(OP_STEP, 32'd0, 1'b1, 32'h0000_8000);

      // Curve overflow: saturated periods push the time past the span,
      // and the denominator then exceeds 64 bits.
      program_ramp(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1);
      send_req(OP_START, 32'd10, 1'b1, 32'hFFFF_FFFF);
      repeat (3) send_req(OP_STEP, 32'd0, 1'b1, 32'hFFFF_FFFF);

      // Every register at its top value; scaling saturates.
      program_ramp(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
      send_req(OP_START, 32'd2, 1'b1, 32'hFFFF_FFFF);
      repeat (2) send_req(OP_STEP, 32'd0, 1'b1, 32'hFFFF_FFFF);

      // Registers at one and the slope at zero: accelerate once, cruise, pop, done.
      program_ramp(48'd1, 48'd1, 32'd0, 32'd1, 32'd1);
      send_req(OP_START, 32'd4, 1'b0, 32'h0001_0000);
      repeat (4) send_req(OP_STEP, 32'd0, 1'b0, 32'h0001_0000);

      // Tiny denominator: the quotient exceeds 32 bits and saturates.
      program_ramp(48'hFFFF_FFFF_FFFF, 48'd1, 32'd1, 32'd2, 32'd1);
      send_req(OP_START, 32'd6, 1'b0, 32'h0001_0000);
      repeat (4) send_req(OP_STEP, 32'd0, 1'b0, 32'h0001_0000);

      // Random part: three idling patterns, three register sets each.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase / 3)
            0: begin tx_idle_pct = 38; rx_idle_pct = 63; end
            1: begin tx_idle_pct = 63; rx_idle_pct = 38; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         random_ramp();
         phase_goal = sent_items + RANDOM_ITEMS / RANDOM_PHASES;
         while (sent_items < phase_goal) begin
            // hold off the sender once until the pipeline is empty
            if (phase == 4 && !paused && sent_items + 60 >= phase_goal) begin
               drain();
               paused = 1'b1;
            end
            random_move();
         end
      end

      // Constant curve above min_period: every step accelerates, so the
      // period stack fills and later periods are no longer saved.
      program_ramp(48'd7, 48'd1, 32'd0, 32'd2, 32'd1);
      send_req(OP_START, 32'(DEEP_COUNT), 1'b0, 32'h0001_0000);
      repeat (DEEP_STEPS) send_req(OP_STEP, $urandom, 1'b0, 32'h0001_0000);

      // Let the last responses arrive, then allow for any stray output.
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("srpg run: %0d requests (%0d move starts) over %0d register sets, %0d responses",
               sent_items, sent_starts, cfg_sets + 1, checked);
      $display("srpg run: stall patterns 38/63, 63/38 and none, stack-fill move of %0d steps",
               DEEP_STEPS);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[stepper_ramp_period_generator] OK");
      end else begin
         $display("[stepper_ramp_period_generator] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/srpg_pkg.sv
rtl/core/srpg_ram.sv
rtl/core/srpg_div.sv
rtl/core/stepper_ramp_period_generator.sv
rtl/core/srpg_checker.sv
tb/srpg_period_checker.sv
tb/tb_top.sv
